>>> rtl/threshold_triggered_peak_finder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the threshold triggered peak finder
// Short forms for clocked concurrent assertions with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_TRIGGERED_PEAK_FINDER_MACROS_SVH
`define THRESHOLD_TRIGGERED_PEAK_FINDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTPF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ttpf_pkg.sv
// ----------------------------------------------------------------------------
// Peak finder package
// Fixed field widths, register indexes and the decoded configuration type.
// ----------------------------------------------------------------------------
package ttpf_pkg;

   // Fixed-point formats.
   localparam int FRAC_BITS    = 16;
   localparam int THRESH_SHIFT = 24;
   localparam int RISE_BITS    = 16;
   localparam int ALPHA_BITS   = 17;
   localparam int WLEN_BITS    = 13;
   localparam int POS_BITS     = 12;

   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE  = 17'h10000;
   localparam logic [WLEN_BITS-1:0]  MAX_WINDOW = 13'd4096;

   // Register reset values.
   localparam logic [RISE_BITS-1:0]  RISE_RESET   = 16'd512;
   localparam logic [ALPHA_BITS-1:0] WEIGHT_RESET = 17'd6554;
   localparam logic [WLEN_BITS-1:0]  WLEN_RESET   = 13'd16;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENABLE = 2'd0,
      CSR_RISE   = 2'd1,
      CSR_WEIGHT = 2'd2,
      CSR_WLEN   = 2'd3
   } csr_index_type;

   // Configuration after saturation, as the datapath uses it.
   typedef struct packed {
      logic                  enable;
      logic [RISE_BITS-1:0]  rise_factor;
      logic [ALPHA_BITS-1:0] alpha;
      logic [WLEN_BITS-1:0]  win_len;
   } cfg_type;

endpackage

>>> rtl/ttpf_req_if.sv
// ----------------------------------------------------------------------------
// Sample request channel
// Valid/ready channel that carries one signed sample per request.
// ----------------------------------------------------------------------------
interface ttpf_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

>>> rtl/ttpf_rsp_if.sv
// ----------------------------------------------------------------------------
// Peak response channel
// Valid/ready channel that carries one detector result per request.
// ----------------------------------------------------------------------------
interface ttpf_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   import ttpf_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          window_done;
   logic [POS_BITS-1:0]           peak_back;
   logic signed [SAMPLE_BITS-1:0] peak_level;
   logic                          searching;

   modport source (output valid, output window_done, output peak_back,
                   output peak_level, output searching, input ready);
   modport sink (input valid, input window_done, input peak_back,
                 input peak_level, input searching, output ready);
endinterface

>>> rtl/ttpf_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface ttpf_csr_if;
   import ttpf_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/ttpf_csr.sv
// ----------------------------------------------------------------------------
// Peak finder configuration registers
// Holds the four registers and presents them saturated to the datapath.
// ----------------------------------------------------------------------------
module ttpf_csr (
   input  logic              clock,
   input  logic              reset,
   ttpf_csr_if.sink          csr,
   output ttpf_pkg::cfg_type cfg
);
   import ttpf_pkg::*;

   logic                  enable_ff;
   logic [RISE_BITS-1:0]  rise_ff;
   logic [ALPHA_BITS-1:0] weight_ff;
   logic [WLEN_BITS-1:0]  wlen_ff;
   logic                  write;

   // Writes are always taken.
   assign csr.ready = 1'b1;
   assign write     = csr.valid;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         rise_ff   <= RISE_RESET;
         weight_ff <= WEIGHT_RESET;
         wlen_ff   <= WLEN_RESET;
      end else if (write) begin
         unique case (csr_index_type'(csr.index))
            CSR_ENABLE: enable_ff <= csr.data[0];
            CSR_RISE:   rise_ff   <= csr.data[RISE_BITS-1:0];
            CSR_WEIGHT: weight_ff <= csr.data[ALPHA_BITS-1:0];
            CSR_WLEN:   wlen_ff   <= csr.data[WLEN_BITS-1:0];
            default:    enable_ff <= enable_ff;
         endcase
      end
   end

   // Saturate the weight to one and the window length to 1..4096.
   always_comb begin
      cfg.enable      = enable_ff;
      cfg.rise_factor = rise_ff;
      cfg.alpha       = (weight_ff > ALPHA_ONE) ? ALPHA_ONE : weight_ff;
      if (wlen_ff == '0) begin
         cfg.win_len = WLEN_BITS'(1);
      end else if (wlen_ff > MAX_WINDOW) begin
         cfg.win_len = MAX_WINDOW;
      end else begin
         cfg.win_len = wlen_ff;
      end
   end

endmodule

>>> rtl/ttpf_avg.sv
// ----------------------------------------------------------------------------
// Peak finder average and threshold unit
// Computes the next exponential average and the rise threshold test.
// ----------------------------------------------------------------------------
module ttpf_avg #(
   parameter int SAMPLE_BITS = 16,
   parameter int AVG_BITS    = SAMPLE_BITS + 17
) (
   input  logic signed [SAMPLE_BITS-1:0]   sample,
   input  logic signed [AVG_BITS-1:0]      avg,
   input  logic [ttpf_pkg::ALPHA_BITS-1:0] alpha,
   input  logic [ttpf_pkg::RISE_BITS-1:0]  rise_factor,
   output logic signed [AVG_BITS-1:0]      avg_next,
   output logic                            above
);
   import ttpf_pkg::*;

   localparam int DIFF_BITS = AVG_BITS + 1;
   localparam int HI_BITS   = DIFF_BITS - FRAC_BITS;
   localparam int HP_BITS   = HI_BITS + ALPHA_BITS + 1;
   localparam int STEP_BITS = HP_BITS + 1;
   localparam int LP_BITS   = ALPHA_BITS + FRAC_BITS;
   localparam int PROD_BITS = AVG_BITS + RISE_BITS + 1;

   logic signed [DIFF_BITS-1:0]  x_scaled;
   logic signed [DIFF_BITS-1:0]  diff;
   logic signed [HI_BITS-1:0]    diff_hi;
   logic [FRAC_BITS-1:0]         diff_lo;
   logic signed [ALPHA_BITS:0]   alpha_s;
   logic signed [HP_BITS-1:0]    hi_prod;
   logic [LP_BITS-1:0]           lo_prod;
   logic signed [STEP_BITS-1:0]  step;
   logic signed [STEP_BITS-1:0]  avg_sum;
   logic signed [PROD_BITS-1:0]  x_thresh;
   logic signed [PROD_BITS-1:0]  avg_thresh;
   logic signed [RISE_BITS:0]    rise_s;

   // Difference between the sample in Q.16 and the average.
   assign x_scaled = {{(DIFF_BITS - SAMPLE_BITS - FRAC_BITS){sample[SAMPLE_BITS-1]}},
                      sample, {FRAC_BITS{1'b0}}};
   assign diff     = x_scaled - DIFF_BITS'(avg);

   // Floor split: diff = hi * 2^16 + lo with lo unsigned.
   assign diff_hi = diff[DIFF_BITS-1:FRAC_BITS];
   assign diff_lo = diff[FRAC_BITS-1:0];
   assign alpha_s = {1'b0, alpha};

   // Step is alpha*hi plus the floored fractional product.
   assign hi_prod  = HP_BITS'(diff_hi * alpha_s);
   assign lo_prod  = alpha * diff_lo;
   assign step     = STEP_BITS'(hi_prod)
                     + STEP_BITS'(signed'({1'b0, lo_prod[LP_BITS-1:FRAC_BITS]}));
   assign avg_sum  = STEP_BITS'(avg) + step;
   assign avg_next = avg_sum[AVG_BITS-1:0];

   // Exact threshold test: sample * 2^24 > avg * rise_factor.
   assign rise_s     = {1'b0, rise_factor};
   assign x_thresh   = {{(PROD_BITS - SAMPLE_BITS - THRESH_SHIFT){sample[SAMPLE_BITS-1]}},
                        sample, {THRESH_SHIFT{1'b0}}};
   assign avg_thresh = PROD_BITS'(avg * rise_s);
   assign above      = x_thresh > avg_thresh;

endmodule

>>> rtl/ttpf_detect.sv
// ----------------------------------------------------------------------------
// Peak finder detection state
// Holds the average and window state and forms the result for one sample.
// ----------------------------------------------------------------------------
module ttpf_detect #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ttpf_pkg::cfg_type               cfg,
   input  logic                            fire,
   input  logic signed [SAMPLE_BITS-1:0]   sample,
   output logic                            res_done,
   output logic [ttpf_pkg::POS_BITS-1:0]   res_back,
   output logic signed [SAMPLE_BITS-1:0]   res_level,
   output logic                            res_searching,
   output logic                            in_window
);
   import ttpf_pkg::*;

   localparam int AVG_BITS = SAMPLE_BITS + 17;

   logic                          in_window_ff;
   logic signed [AVG_BITS-1:0]    avg_ff;
   logic [POS_BITS-1:0]           pos_ff;
   logic signed [SAMPLE_BITS-1:0] best_ff;
   logic [POS_BITS-1:0]           bpos_ff;

   logic signed [AVG_BITS-1:0]    avg_next;
   logic                          above;
   logic                          open;
   logic                          take;
   logic                          last;
   logic [POS_BITS-1:0]           pos_eff;
   logic signed [SAMPLE_BITS-1:0] best_new;
   logic [POS_BITS-1:0]           bpos_new;
   logic                          update;

   ttpf_avg #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AVG_BITS    (AVG_BITS)
   ) u_avg (
      .sample      (sample),
      .avg         (avg_ff),
      .alpha       (cfg.alpha),
      .rise_factor (cfg.rise_factor),
      .avg_next    (avg_next),
      .above       (above)
   );

   // Window decisions for the current sample.
   assign open     = in_window_ff || above;
   assign pos_eff  = in_window_ff ? pos_ff : '0;
   assign take     = open && ((pos_eff == '0) || (sample > best_ff));
   assign last     = ({1'b0, pos_eff} + WLEN_BITS'(1)) >= cfg.win_len;
   assign best_new = take ? sample : best_ff;
   assign bpos_new = take ? pos_eff : bpos_ff;
   assign update   = fire && cfg.enable;

   // State update, frozen while disabled.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_window_ff <= 1'b0;
         avg_ff       <= '0;
         pos_ff       <= '0;
         best_ff      <= '0;
         bpos_ff      <= '0;
      end else if (update) begin
         if (take || !open) begin
            avg_ff <= avg_next;
         end
         if (open) begin
            best_ff <= best_new;
            bpos_ff <= bpos_new;
            if (last) begin
               in_window_ff <= 1'b0;
               pos_ff       <= '0;
            end else begin
               in_window_ff <= 1'b1;
               pos_ff       <= pos_eff + POS_BITS'(1);
            end
         end
      end
   end

   // Result fields; all zero while disabled or idle.
   always_comb begin
      res_done      = 1'b0;
      res_back      = '0;
      res_level     = '0;
      res_searching = 1'b0;
      if (cfg.enable && open) begin
         if (last) begin
            res_done  = 1'b1;
            res_back  = pos_eff - bpos_new;
            res_level = best_new;
         end else begin
            res_searching = 1'b1;
         end
      end
   end

   assign in_window = in_window_ff;

endmodule

>>> rtl/threshold_triggered_peak_finder.sv
// ----------------------------------------------------------------------------
// Threshold triggered peak finder
// Adaptive threshold detector that reports the peak of each search window.
// ----------------------------------------------------------------------------
// Usage: samples arrive as requests on req_bus, one signed sample each. Every
// request yields exactly one response on rsp_bus, in order, carrying
// window_done, peak_back, peak_level and searching. Registers are written on
// csr_bus (index 0 enable, 1 rise factor, 2 smoothing weight, 3 window
// length); writes are always taken, but the user must issue them only
// while no request is in flight; the block itself does not enforce this.
// Pipeline: a request accepted into the input register is processed once the
// response register is free or being read; its result is then loaded into
// the response register, which drives rsp_bus.
// Throughput: one request per cycle while the receiver does not stall. The
// next average and window state are computed combinationally, so the average
// multiply-add and the threshold multiply set the clock period.
// Reset (synchronous) clears the pipeline, returns the detector to idle with
// a zero average and loads the register defaults.
// When the receiver stalls, the response register holds and one further
// request is still taken into the input register; then req_bus.ready drops.
// ----------------------------------------------------------------------------
`include "threshold_triggered_peak_finder_macros.svh"

module threshold_triggered_peak_finder #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   ttpf_req_if.sink   req_bus,
   ttpf_rsp_if.source rsp_bus,
   ttpf_csr_if.sink   csr_bus
);
   import ttpf_pkg::*;

   cfg_type                       cfg;
   logic                          in_valid_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic                          advance;

   logic                          rsp_valid_ff;
   logic                          done_ff;
   logic [POS_BITS-1:0]           back_ff;
   logic signed [SAMPLE_BITS-1:0] level_ff;
   logic                          searching_ff;

   logic                          res_done;
   logic [POS_BITS-1:0]           res_back;
   logic signed [SAMPLE_BITS-1:0] res_level;
   logic                          res_searching;
   logic                          in_window;

   ttpf_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   ttpf_detect #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_detect (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .fire          (advance),
      .sample        (x_ff),
      .res_done      (res_done),
      .res_back      (res_back),
      .res_level     (res_level),
      .res_searching (res_searching),
      .in_window     (in_window)
   );

   // Handshake: the input stage moves on when the response register is empty or is being read.
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         x_ff <= req_bus.sample;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         done_ff      <= res_done;
         back_ff      <= res_back;
         level_ff     <= res_level;
         searching_ff <= res_searching;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.window_done = done_ff;
   assign rsp_bus.peak_back   = back_ff;
   assign rsp_bus.peak_level  = level_ff;
   assign rsp_bus.searching   = searching_ff;

   // Checks on the block's own logic.
   `TTPF_ASSERT_NOW(a_stall_full, clock, reset, !req_bus.ready, in_valid_ff && rsp_valid_ff, "request stalled with a free stage")
   `TTPF_ASSERT_NOW(a_disabled_zero, clock, reset, rsp_valid_ff && !cfg.enable, !done_ff && !searching_ff && back_ff == '0 && level_ff == '0, "disabled response not zero")
   `TTPF_ASSERT_NOW(a_done_alone, clock, reset, rsp_valid_ff, !(done_ff && searching_ff), "done while searching")
   `TTPF_ASSERT_NEXT(a_window_state, clock, reset, !reset && advance && cfg.enable, in_window == searching_ff, "window state disagrees with response")

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Peak finder testbench
// Drives sample requests with random bursts and gaps, stalls the response
// channel on a changing pattern and writes the registers between phases. A
// directed table covers the register extremes and the window corner cases.
// Random phases follow. Each response is compared with its typed table entry,
// else with a cycle-free detector model tracking average, window and registers.
// ----------------------------------------------------------------------------
module testbench;
   import ttpf_pkg::*;

   localparam int SAMPLE_BITS  = 16;
   localparam int RANDOM_ITEMS = 1630;

   // One detector result, in the order the response channel carries it.
   typedef struct packed {
      logic                          done;
      logic [POS_BITS-1:0]           back;
      logic signed [SAMPLE_BITS-1:0] level;
      logic                          searching;
   } peak_report_type;

   typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   // One row of the directed table: a sample request or a register write.
   typedef struct packed {
      row_kind_type                  kind;
      csr_index_type                 sel;
      logic [CSR_DATA_BITS-1:0]      value;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          typed;
      peak_report_type               want;
   } stim_row_type;

   localparam peak_report_type NO_REPORT = '0;
   localparam peak_report_type SEARCHING = '{1'b0, 12'd0, 16'sd0, 1'b1};

   localparam stim_row_type DIRECTED_ROWS [27] = '{
      // Disabled after reset: every field is zero.
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, 16'sh7FFF, 1'b1, NO_REPORT},
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, -16'sh8000, 1'b1, NO_REPORT},
      '{ROW_WRITE,  CSR_ENABLE, 17'd1, 16'sd0, 1'b0, NO_REPORT},
      // A zero average with the default factor keeps these below threshold.
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, 16'sd0, 1'b1, NO_REPORT},
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, -16'sh8000, 1'b1, NO_REPORT},
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, -16'sh8000, 1'b0, NO_REPORT},
      // One-sample window on the largest sample.
      '{ROW_WRITE,  CSR_WLEN,   17'd1, 16'sd0, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, 16'sh7FFF, 1'b1, '{1'b1, 12'd0, 16'sh7FFF, 1'b0}},
      // Zero factor: any positive sample crosses; zero length acts as one.
      '{ROW_WRITE,  CSR_RISE,   17'd0, 16'sd0, 1'b0, NO_REPORT},
      '{ROW_WRITE,  CSR_WLEN,   17'd0, 16'sd0, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, 16'sd1, 1'b1, '{1'b1, 12'd0, 16'sd1, 1'b0}},
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, 16'sd0, 1'b1, NO_REPORT},
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, -16'sd1, 1'b1, NO_REPORT},
      // Three-sample window: a repeated maximum keeps the first one.
      '{ROW_WRITE,  CSR_WLEN,   17'd3, 16'sd0, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, 16'sd5, 1'b1, SEARCHING},
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, 16'sd9, 1'b1, SEARCHING},
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, 16'sd9, 1'b1, '{1'b1, 12'd1, 16'sd9, 1'b0}},
      // Open a window, disable mid-window, then shorten it on re-enable.
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, 16'sd7, 1'b1, SEARCHING},
      '{ROW_WRITE,  CSR_ENABLE, 17'd0, 16'sd0, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, 16'sd100, 1'b1, NO_REPORT},
      '{ROW_WRITE,  CSR_ENABLE, 17'd1, 16'sd0, 1'b0, NO_REPORT},
      '{ROW_WRITE,  CSR_WLEN,   17'd1, 16'sd0, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, 16'sd3, 1'b1, '{1'b1, 12'd1, 16'sd7, 1'b0}},
      // Largest factor and a weight of one.
      '{ROW_WRITE,  CSR_RISE,   17'd65535, 16'sd0, 1'b0, NO_REPORT},
      '{ROW_WRITE,  CSR_WEIGHT, 17'd65536, 16'sd0, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, -16'sd1, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, CSR_ENABLE, 17'd0, 16'sh7FFF, 1'b0, NO_REPORT}
   };

   logic clock;
   logic reset;

   ttpf_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   ttpf_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();
   ttpf_csr_if csr_bus ();

   threshold_triggered_peak_finder #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   // Register copies as last written.
   logic                  reg_enable = 1'b0;
   logic [RISE_BITS-1:0]  reg_rise   = RISE_RESET;
   logic [ALPHA_BITS-1:0] reg_weight = WEIGHT_RESET;
   logic [WLEN_BITS-1:0]  reg_wlen   = WLEN_RESET;

   // Detector state: window flag and position, Q.16 average and the best sample and its position.
   logic                          win_open   = 1'b0;
   logic signed [32:0]            avg_q16    = '0;
   logic [POS_BITS-1:0]           win_pos    = '0;
   logic signed [SAMPLE_BITS-1:0] best_level = '0;
   logic [POS_BITS-1:0]           best_pos   = '0;

   peak_report_type pending_reports[$];
   int              fault_count = 0;
   int              burst_left  = 0;
   logic [7:0]      stall_mask  = 8'hFF;
   logic [7:0]      stall_tick  = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Move the average toward x by alpha times the difference, rounded down.
   function automatic void smooth_toward(logic signed [SAMPLE_BITS-1:0] x);
      longint alpha;
      longint diff;
      alpha = (reg_weight > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(reg_weight);
      diff = longint'(x) * 65536 - longint'(avg_q16);
      avg_q16 = 33'(longint'(avg_q16) + ((alpha * diff) >>> 16));
   endfunction

   // Advance the detector by one sample and return the result it reports.
   function automatic peak_report_type detect_step(logic signed [SAMPLE_BITS-1:0] x);
      peak_report_type r;
      int unsigned     span;
      r = NO_REPORT;
      if (!reg_enable) begin
         return r;
      end
      if (!win_open) begin
         if ((longint'(x) <<< 24) > longint'(avg_q16) * longint'(reg_rise)) begin
            win_open = 1'b1;
            win_pos = '0;
         end else begin
            smooth_toward(x);
            return r;
         end
      end
      span = (reg_wlen == 0) ? 1 : (reg_wlen > MAX_WINDOW) ? MAX_WINDOW : reg_wlen;
      // The first sample of a window is always taken as the maximum.
      if (win_pos == 0 || x > best_level) begin
         best_level = x;
         best_pos = win_pos;
         smooth_toward(x);
      end
      if (int'(win_pos) + 1 >= span) begin
         r.done = 1'b1;
         r.back = win_pos - best_pos;
         r.level = best_level;
         win_open = 1'b0;
         win_pos = '0;
      end else begin
         win_pos = win_pos + 1'b1;
         r.searching = 1'b1;
      end
      return r;
   endfunction

   // Send one sample request and queue its expected result on acceptance.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x, input bit typed,
                              input peak_report_type typed_want);
      peak_report_type predicted;
      int              gap;
      req_bus.valid <= 1'b1;
      req_bus.sample <= x;
      do @(posedge clock); while (!req_bus.ready);
      predicted = detect_step(x);
      pending_reports.push_back(typed ? typed_want : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end
      // At the end of a burst, pick the idle gap and the next burst length.
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 20);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Write one register once every outstanding request has been answered.
   task automatic write_register(input csr_index_type sel,
                                 input logic [CSR_DATA_BITS-1:0] value);
      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= sel;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (sel)
         CSR_ENABLE: reg_enable = value[0];
         CSR_RISE:   reg_rise = value[RISE_BITS-1:0];
         CSR_WEIGHT: reg_weight = value[ALPHA_BITS-1:0];
         CSR_WLEN:   reg_wlen = value[WLEN_BITS-1:0];
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
   endtask

   // Response side: compare each accepted response and stall on a pattern.
   always @(posedge clock) begin
      peak_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_reports.size() == 0) begin
            $error("response with no request pending");
            fault_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_bus.window_done !== want.done) begin
               $error("window_done expected %0d, got %0d", want.done, rsp_bus.window_done);
               fault_count++;
            end
            if (rsp_bus.peak_back !== want.back) begin
               $error("peak_back expected %0d, got %0d", want.back, rsp_bus.peak_back);
               fault_count++;
            end
            if (rsp_bus.peak_level !== want.level) begin
               $error("peak_level expected %0d, got %0d", want.level, rsp_bus.peak_level);
               fault_count++;
            end
            if (rsp_bus.searching !== want.searching) begin
               $error("searching expected %0d, got %0d", want.searching, rsp_bus.searching);
               fault_count++;
            end
         end
      end
      // A new stall pattern whenever the low six tick bits return to zero; some patterns never stall.
      stall_tick = stall_tick + 1'b1;
      if (stall_tick[5:0] == 0) begin
         stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      rsp_bus.ready <= stall_mask[stall_tick[2:0]];
   end

   // Stimulus: directed table, then random phases.
   initial begin
      int                            random_sent;
      int                            level;
      int                            noise;
      int                            phase_len;
      int                            v;
      logic [CSR_DATA_BITS-1:0]      value;
      logic signed [SAMPLE_BITS-1:0] x;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_ENABLE;
      csr_bus.data = '0;
      random_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
            write_register(DIRECTED_ROWS[i].sel, DIRECTED_ROWS[i].value);
         end else begin
            send_sample(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].typed,
                        DIRECTED_ROWS[i].want);
         end
      end

      while (random_sent < RANDOM_ITEMS) begin
         // Rewrite about half of the registers, often at their extremes.
         for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 1) == 1) begin
               value = 17'($urandom);
               case (csr_index_type'(k))
                  CSR_ENABLE: value[0] = ($urandom_range(0, 7) != 0);
                  CSR_RISE: begin
                     case ($urandom_range(0, 5))
                        0: value[15:0] = '0;
                        1: value[15:0] = '1;
                        2, 3: value[15:0] = 16'($urandom_range(256, 1024));
                        4: value[15:0] = 16'($urandom_range(128, 320));
                        default: ;
                     endcase
                  end
                  CSR_WEIGHT: begin
                     case ($urandom_range(0, 5))
                        0: value = '0;
                        1: value = 17'd65536;
                        2: value = 17'($urandom_range(65537, 131071));
                        3, 4: value = 17'($urandom_range(1, 65535));
                        default: value = '1;
                     endcase
                  end
                  default: begin
                     case ($urandom_range(0, 15))
                        0: value[12:0] = '0;
                        1: value[12:0] = 13'd1;
                        2: value[12:0] = 13'($urandom_range(4096, 8191));
                        default: value[12:0] = 13'($urandom_range(2, 24));
                     endcase
                  end
               endcase
               write_register(csr_index_type'(k), value);
            end
         end

         // A noisy baseline with spikes, some full-range noise and extremes.
         level = int'($urandom_range(0, 4000)) - 2000;
         noise = 1 << $urandom_range(0, 8);
         phase_len = $urandom_range(10, 80);
         repeat (phase_len) begin
            case ($urandom_range(0, 99)) inside
               [0:64]:  v = level + int'($urandom_range(0, 2 * noise)) - noise;
               [65:84]: v = level + int'($urandom_range(500, 20000));
               [85:96]: v = int'($urandom);
               [97:98]: v = 32767;
               default: v = -32768;
            endcase
            x = 16'(v);
            send_sample(x, 1'b0, NO_REPORT);
            random_sent++;
         end
      end

      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fault_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Watchdog for a stalled handshake.
   initial begin
      #2_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
